// File: rtl/omws_pkg.sv
`timescale 1ns / 1ps

package omws_pkg;

   localparam int CMD_W   = 17;  // Q8 command words
   localparam int XS_W    = 33;  // X * sin60, Q24
   localparam int WHEEL_W = 35;  // signed wheel speed, Q24
   localparam int MAG_W   = 34;  // wheel magnitude, Q24
   localparam int PCT_W   = 7;   // percent 0..100
   localparam int REM_W   = MAG_W + PCT_W + 1;  // divider remainder
   localparam int DUTY_W  = 8;
   localparam int NUM_WHEELS = 3;

   // sin60 in unsigned Q16, held as a positive signed operand
   localparam logic signed [17:0] SIN60_Q16 = 18'sd56756;
   localparam logic [MAG_W-1:0] ONE_Q24 = MAG_W'(2 ** 24);
   localparam int PCT_SCALE = 100;

   // percent * 255 / 100 as multiply by 255 * ceil(2^19 / 100), then shift
   localparam int DUTY_SHIFT = 19;
   localparam int DUTY_MUL_W = 21;
   localparam logic [DUTY_MUL_W-1:0] DUTY_MUL = DUTY_MUL_W'(255 * 5243);
   localparam int DUTY_PROD_W = PCT_W + DUTY_MUL_W;

   typedef logic signed [CMD_W-1:0] cmd_type;

   typedef struct packed {
      logic                              valid;
      logic [NUM_WHEELS-1:0]             neg;
      logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag;
   } mag_beat_type;

   typedef struct packed {
      logic                              valid;
      logic [NUM_WHEELS-1:0]             neg;
      logic [REM_W-1:0]                  den;
      logic [NUM_WHEELS-1:0][REM_W-1:0]  rem;
      logic [NUM_WHEELS-1:0][PCT_W-1:0]  quo;
   } div_beat_type;

endpackage

// File: rtl/omni_wheel_speed_mixer_core.sv
`timescale 1ns / 1ps

// Three-wheel omni drive speed mixer. Takes one motion command (X sideways,
// Y forward, W rotation, signed Q8) per beat and returns three wheel duties
// (0..255) with one direction bit per wheel. The core is a fixed 11-stage
// pipeline: a command is taken in any cycle in which start is high and busy
// is low. Its result is on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, once the command has passed through every stage. One command per
// cycle is sustained while busy is low; busy is set during reset, cleared by the
// first clock edge after reset is released, and never set otherwise. The receiver
// cannot stall the core, so results must be captured on the strobe cycle.
module omni_wheel_speed_mixer_core import omws_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_speed_x,
   input  logic [CMD_W-1:0]   req_speed_y,
   input  logic [CMD_W-1:0]   req_speed_w,
   output logic               rsp_valid,
   output logic [DUTY_W-1:0]  rsp_duty_a,
   output logic               rsp_reverse_a,
   output logic [DUTY_W-1:0]  rsp_duty_b,
   output logic               rsp_reverse_b,
   output logic [DUTY_W-1:0]  rsp_duty_c,
   output logic               rsp_reverse_c
);

   // Pipeline map:
   //   2 stages  mix: X*sin60, then wheel sums, sign and magnitude (Q24)
   //   1 stage   normalize: divisor is 1.0, or the largest magnitude if over 1.0
   //   7 stages  percent = floor(100*|wheel| / divisor), one quotient bit each
   //   1 stage   duty = floor(percent*255/100) by reciprocal multiply
   // A zero wheel speed falls out as percent 0, duty 0, reverse 0.

   logic                              busy_ff;
   logic                              accept;
   mag_beat_type                      mix_beat;
   div_beat_type                      div_bus [PCT_W+1];
   logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty;
   logic [NUM_WHEELS-1:0]             rev;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   omws_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .speed_x  (cmd_type'(req_speed_x)),
      .speed_y  (cmd_type'(req_speed_y)),
      .speed_w  (cmd_type'(req_speed_w)),
      .out_beat (mix_beat)
   );

   omws_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (mix_beat),
      .out_beat (div_bus[0])
   );

   // one quotient bit per stage, MSB first
   for (genvar g = 0; g < PCT_W; g++) begin : g_div
      omws_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_beat  (div_bus[g]),
         .out_beat (div_bus[g+1])
      );
   end

   omws_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (div_bus[PCT_W]),
      .out_valid (rsp_valid),
      .out_duty  (duty),
      .out_rev   (rev)
   );

   assign rsp_duty_a    = duty[0];
   assign rsp_reverse_a = rev[0];
   assign rsp_duty_b    = duty[1];
   assign rsp_reverse_b = rev[1];
   assign rsp_duty_c    = duty[2];
   assign rsp_reverse_c = rev[2];

endmodule

// File: rtl/omws_mix.sv
`timescale 1ns / 1ps

module omws_mix import omws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  cmd_type      speed_x,
   input  cmd_type      speed_y,
   input  cmd_type      speed_w,
   output mag_beat_type out_beat
);

   // stage 1: X * sin60
   logic                    v1_ff;
   logic signed [XS_W-1:0]  xs_ff;
   logic signed [XS_W-1:0]  xs_in;
   cmd_type                 y_ff;
   cmd_type                 w_ff;

   // stage 2: wheel mix, sign and magnitude
   mag_beat_type            beat_ff;
   mag_beat_type            beat_in;

   logic signed [WHEEL_W-1:0] xs_e;
   logic signed [WHEEL_W-1:0] yh_e;
   logic signed [WHEEL_W-1:0] yf_e;
   logic signed [WHEEL_W-1:0] wf_e;
   logic signed [NUM_WHEELS-1:0][WHEEL_W-1:0] sum;
   logic [WHEEL_W-1:0]        neg_sum;

   assign xs_in = speed_x * SIN60_Q16;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      xs_ff <= xs_in;
      y_ff  <= speed_y;
      w_ff  <= speed_w;
   end

   always_comb begin
      xs_e = WHEEL_W'(xs_ff);
      yh_e = WHEEL_W'(y_ff) <<< 15;
      yf_e = WHEEL_W'(y_ff) <<< 16;
      wf_e = WHEEL_W'(w_ff) <<< 16;
      sum[0] = yh_e + wf_e - xs_e;
      sum[1] = wf_e - yf_e;
      sum[2] = yh_e + wf_e + xs_e;
      beat_in.valid = v1_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         neg_sum = -sum[i];
         beat_in.neg[i] = sum[i][WHEEL_W-1];
         beat_in.mag[i] = sum[i][WHEEL_W-1] ? neg_sum[MAG_W-1:0] : sum[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.neg <= beat_in.neg;
      beat_ff.mag <= beat_in.mag;
   end

   assign out_beat = beat_ff;

endmodule

// File: rtl/omws_norm.sv
`timescale 1ns / 1ps

module omws_norm import omws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mag_beat_type in_beat,
   output div_beat_type out_beat
);

   div_beat_type      beat_ff;
   div_beat_type      beat_in;
   logic [MAG_W-1:0]  max01;
   logic [MAG_W-1:0]  max_all;
   logic [MAG_W-1:0]  divisor;
   logic              over;

   always_comb begin
      max01   = (in_beat.mag[1] > in_beat.mag[0]) ? in_beat.mag[1] : in_beat.mag[0];
      max_all = (in_beat.mag[2] > max01) ? in_beat.mag[2] : max01;
      over    = max_all > ONE_Q24;
      divisor = over ? max_all : ONE_Q24;
      beat_in.valid = in_beat.valid;
      beat_in.neg   = in_beat.neg;
      // divisor aligned to the top quotient bit
      beat_in.den   = REM_W'(divisor) << (PCT_W - 1);
      for (int i = 0; i < NUM_WHEELS; i++) begin
         beat_in.rem[i] = REM_W'(in_beat.mag[i]) * REM_W'(PCT_SCALE);
         beat_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.neg <= beat_in.neg;
      beat_ff.den <= beat_in.den;
      beat_ff.rem <= beat_in.rem;
      beat_ff.quo <= beat_in.quo;
   end

   assign out_beat = beat_ff;

endmodule

// File: rtl/omws_div_stage.sv
`timescale 1ns / 1ps

// One restoring-division step per wheel: one quotient bit, remainder shifted left.
module omws_div_stage import omws_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_beat_type in_beat,
   output div_beat_type out_beat
);

   div_beat_type      beat_ff;
   div_beat_type      beat_in;
   logic              ge;
   logic [REM_W-1:0]  kept;

   always_comb begin
      beat_in.valid = in_beat.valid;
      beat_in.neg   = in_beat.neg;
      beat_in.den   = in_beat.den;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         ge   = in_beat.rem[i] >= in_beat.den;
         kept = ge ? (in_beat.rem[i] - in_beat.den) : in_beat.rem[i];
         beat_in.rem[i] = kept << 1;
         beat_in.quo[i] = {in_beat.quo[i][PCT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.neg <= beat_in.neg;
      beat_ff.den <= beat_in.den;
      beat_ff.rem <= beat_in.rem;
      beat_ff.quo <= beat_in.quo;
   end

   assign out_beat = beat_ff;

endmodule

// File: rtl/omws_duty.sv
`timescale 1ns / 1ps

module omws_duty import omws_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  div_beat_type                      in_beat,
   output logic                              out_valid,
   output logic [NUM_WHEELS-1:0][DUTY_W-1:0] out_duty,
   output logic [NUM_WHEELS-1:0]             out_rev
);

   logic                              valid_ff;
   logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty_ff;
   logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty_in;
   logic [NUM_WHEELS-1:0]             rev_ff;
   logic [DUTY_PROD_W-1:0]            prod;

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         prod = DUTY_PROD_W'(in_beat.quo[i]) * DUTY_PROD_W'(DUTY_MUL);
         duty_in[i] = prod[DUTY_SHIFT +: DUTY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_beat.valid;
      end
      duty_ff <= duty_in;
      rev_ff  <= in_beat.neg;
   end

   assign out_valid = valid_ff;
   assign out_duty  = duty_ff;
   assign out_rev   = rev_ff;

endmodule
